FILE: hw/rtl/cmphd_pkg.sv
package cmphd_pkg;

    // Angle accumulator width, Q9.7 degrees
    localparam int Z_W       = 16;
    // CORDIC datapath width: 33-bit product scaled by 2^16 plus growth headroom
    localparam int A_W       = 50;
    localparam int PROD_W    = 33;
    localparam int FRAC_SH   = 16;
    localparam int ATAN_LEN  = 24;
    localparam int ATAN_IW   = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam logic signed [Z_W-1:0] QUARTER_Q7 = 16'sd11520;
    localparam logic signed [Z_W:0]   FULL_Q7    = 17'sd46080;
    localparam logic [8:0]            DEG_FULL   = 9'd360;
    localparam logic [8:0]            DEG_HALF   = 9'd180;

    localparam logic [2:0] REG_X_OFFSET = 3'd0;
    localparam logic [2:0] REG_X_SCALE  = 3'd1;
    localparam logic [2:0] REG_Y_OFFSET = 3'd2;
    localparam logic [2:0] REG_Y_SCALE  = 3'd3;
    localparam logic [2:0] REG_MIN_INT  = 3'd4;

    // What the back end does with a queued item
    localparam logic [1:0] KIND_HOLD   = 2'd0;
    localparam logic [1:0] KIND_FIXED  = 2'd1;
    localparam logic [1:0] KIND_CORDIC = 2'd2;

    typedef struct packed {
        logic signed [15:0] x_offset;
        logic        [14:0] x_scale;
        logic signed [15:0] y_offset;
        logic        [14:0] y_scale;
        logic        [7:0]  min_interval_ms;
    } t_cfg;

    typedef struct packed {
        logic        [1:0]  kind;
        logic        [8:0]  fixed_heading;
        logic               fixed_no_heading;
        logic signed [16:0] xc;
        logic signed [16:0] yc;
    } t_job;

    // atan(2^-i) in Q9.7 degrees, rounded
    function automatic logic signed [Z_W-1:0] atan_q7(input logic [ATAN_IW-1:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 16'sd5760;
            5'd1:    v = 16'sd3400;
            5'd2:    v = 16'sd1797;
            5'd3:    v = 16'sd912;
            5'd4:    v = 16'sd458;
            5'd5:    v = 16'sd229;
            5'd6:    v = 16'sd115;
            5'd7:    v = 16'sd57;
            5'd8:    v = 16'sd29;
            5'd9:    v = 16'sd14;
            5'd10:   v = 16'sd7;
            5'd11:   v = 16'sd4;
            5'd12:   v = 16'sd2;
            5'd13:   v = 16'sd1;
            default: v = 16'sd0;
        endcase
        return v;
    endfunction

endpackage

FILE: hw/rtl/cmphd_front.sv
module cmphd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cmphd_pkg::t_cfg    i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [31:0]        i_now_ms,
    input  logic signed [15:0] i_x_raw,
    input  logic signed [15:0] i_y_raw,
    input  logic               i_q_full,
    output logic               o_push,
    output cmphd_pkg::t_job    o_job
);

    logic [31:0]        r_last_ms;
    logic [31:0]        elapsed;
    logic               fresh;
    logic signed [16:0] xc;
    logic signed [16:0] yc;
    logic               x_pos;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    assign elapsed = i_now_ms - r_last_ms;
    assign fresh   = elapsed > {24'd0, i_cfg.min_interval_ms};
    assign xc      = {i_x_raw[15], i_x_raw} + {i_cfg.x_offset[15], i_cfg.x_offset};
    assign yc      = {i_y_raw[15], i_y_raw} + {i_cfg.y_offset[15], i_cfg.y_offset};
    assign x_pos   = !xc[16] && (xc != 17'sd0);

    always_comb begin
        o_job.xc               = xc;
        o_job.yc               = yc;
        o_job.fixed_heading    = 9'd0;
        o_job.fixed_no_heading = 1'b0;
        if (!fresh) begin
            o_job.kind = cmphd_pkg::KIND_HOLD;
        end else if (yc == 17'sd0) begin
            // no y component: due north when x points forward, else no heading
            o_job.kind             = cmphd_pkg::KIND_FIXED;
            o_job.fixed_heading    = x_pos ? cmphd_pkg::DEG_FULL : 9'd0;
            o_job.fixed_no_heading = !x_pos;
        end else if (xc == 17'sd0) begin
            o_job.kind          = cmphd_pkg::KIND_FIXED;
            o_job.fixed_heading = yc[16] ? cmphd_pkg::DEG_HALF : cmphd_pkg::DEG_FULL;
        end else begin
            o_job.kind = cmphd_pkg::KIND_CORDIC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_ms <= 32'd0;
        end else if (o_push && fresh) begin
            r_last_ms <= i_now_ms;
        end
    end

endmodule

FILE: hw/rtl/cmphd_queue.sv
module cmphd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cmphd_pkg::t_job i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output cmphd_pkg::t_job o_job
);

    localparam int PTR_W = $clog2(cmphd_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(cmphd_pkg::QUEUE_DEPTH + 1);

    cmphd_pkg::t_job r_mem [cmphd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = r_count == CNT_W'(cmphd_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(cmphd_pkg::QUEUE_DEPTH - 1)) ? '0 :
                            r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(cmphd_pkg::QUEUE_DEPTH - 1)) ? '0 :
                            r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/cmphd_back.sv
module cmphd_back #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cmphd_pkg::t_cfg i_cfg,
    input  logic            i_q_valid,
    input  cmphd_pkg::t_job i_q_job,
    output logic            o_q_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [8:0]      o_heading_deg,
    output logic            o_no_heading,
    output logic            o_fresh
);

    localparam int A_W    = cmphd_pkg::A_W;
    localparam int Z_W    = cmphd_pkg::Z_W;
    localparam int ITER_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_PRE  = 3'd2;
    localparam logic [2:0] ST_ITER = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]             r_state;
    cmphd_pkg::t_job        r_job;
    logic signed [A_W-1:0]  r_a;
    logic signed [A_W-1:0]  r_b;
    logic signed [Z_W-1:0]  r_z;
    logic [ITER_W-1:0]      r_iter;
    logic [8:0]             r_held_heading;
    logic                   r_held_no_heading;
    logic                   r_out_valid;
    logic [8:0]             r_out_heading;
    logic                   r_out_no_heading;
    logic                   r_out_fresh;

    logic [14:0]                       sx;
    logic [14:0]                       sy;
    logic signed [cmphd_pkg::PROD_W-1:0] prod_a;
    logic signed [cmphd_pkg::PROD_W-1:0] prod_b;
    logic signed [A_W-1:0]             da;
    logic signed [A_W-1:0]             db;
    logic signed [Z_W-1:0]             atan_v;
    logic signed [Z_W:0]               z_wrap;
    logic signed [Z_W:0]               rem;
    logic [8:0]                        cordic_deg;
    logic                              out_free;
    logic                              load_out;
    logic [8:0]                        res_heading;
    logic                              res_no_heading;

    // zero scale acts as one
    assign sx = (i_cfg.x_scale == 15'd0) ? 15'd1 : i_cfg.x_scale;
    assign sy = (i_cfg.y_scale == 15'd0) ? 15'd1 : i_cfg.y_scale;
    assign prod_a = r_job.yc * $signed({1'b0, sx});
    assign prod_b = r_job.xc * $signed({1'b0, sy});

    assign da     = r_b >>> r_iter;
    assign db     = r_a >>> r_iter;
    assign atan_v = cmphd_pkg::atan_q7(cmphd_pkg::ATAN_IW'(r_iter));

    // wrap to [0,360) then take 360 minus angle, whole degrees
    assign z_wrap = r_z[Z_W-1] ? ({r_z[Z_W-1], r_z} + cmphd_pkg::FULL_Q7) : {1'b0, r_z};
    assign rem    = cmphd_pkg::FULL_Q7 - z_wrap;
    always_comb begin
        if (rem[Z_W]) begin
            cordic_deg = 9'd0;
        end else if (rem[Z_W-1:7] > 9'(cmphd_pkg::DEG_FULL)) begin
            cordic_deg = cmphd_pkg::DEG_FULL;
        end else begin
            cordic_deg = rem[15:7];
        end
    end

    always_comb begin
        case (r_job.kind)
            cmphd_pkg::KIND_FIXED: begin
                res_heading    = r_job.fixed_heading;
                res_no_heading = r_job.fixed_no_heading;
            end
            cmphd_pkg::KIND_CORDIC: begin
                res_heading    = cordic_deg;
                res_no_heading = 1'b0;
            end
            default: begin
                res_heading    = r_held_heading;
                res_no_heading = r_held_no_heading;
            end
        endcase
    end

    assign out_free      = !r_out_valid || i_ready;
    assign load_out      = (r_state == ST_DONE) && out_free;
    assign o_q_pop       = (r_state == ST_IDLE) && i_q_valid;
    assign o_valid       = r_out_valid;
    assign o_heading_deg = r_out_heading;
    assign o_no_heading  = r_out_no_heading;
    assign o_fresh       = r_out_fresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= ST_IDLE;
            r_held_heading    <= 9'd0;
            r_held_no_heading <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_state <= (i_q_job.kind == cmphd_pkg::KIND_CORDIC) ? ST_MUL : ST_DONE;
                    end
                end
                ST_MUL:  r_state <= ST_PRE;
                ST_PRE:  r_state <= ST_ITER;
                ST_ITER: begin
                    if (r_iter == ITER_W'(CORDIC_STEPS - 1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            if (load_out) begin
                r_out_valid <= 1'b1;
                if (r_job.kind != cmphd_pkg::KIND_HOLD) begin
                    r_held_heading    <= res_heading;
                    r_held_no_heading <= res_no_heading;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job <= i_q_job;
        end
        if (load_out) begin
            r_out_heading    <= res_heading;
            r_out_no_heading <= res_no_heading;
            r_out_fresh      <= r_job.kind != cmphd_pkg::KIND_HOLD;
        end
        case (r_state)
            ST_MUL: begin
                r_a <= {{(A_W - cmphd_pkg::PROD_W - cmphd_pkg::FRAC_SH){prod_a[cmphd_pkg::PROD_W-1]}},
                        prod_a, {cmphd_pkg::FRAC_SH{1'b0}}};
                r_b <= {{(A_W - cmphd_pkg::PROD_W - cmphd_pkg::FRAC_SH){prod_b[cmphd_pkg::PROD_W-1]}},
                        prod_b, {cmphd_pkg::FRAC_SH{1'b0}}};
                r_z    <= '0;
                r_iter <= '0;
            end
            ST_PRE: begin
                // bring the vector into the right half-plane
                if (r_a[A_W-1]) begin
                    if (!r_b[A_W-1]) begin
                        r_a <= r_b;
                        r_b <= -r_a;
                        r_z <= cmphd_pkg::QUARTER_Q7;
                    end else begin
                        r_a <= -r_b;
                        r_b <= r_a;
                        r_z <= -cmphd_pkg::QUARTER_Q7;
                    end
                end
            end
            ST_ITER: begin
                if (!r_b[A_W-1]) begin
                    r_a <= r_a + da;
                    r_b <= r_b - db;
                    r_z <= r_z + atan_v;
                end else begin
                    r_a <= r_a - da;
                    r_b <= r_b + db;
                    r_z <= r_z - atan_v;
                end
                r_iter <= r_iter + 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: hw/rtl/compass_heading_from_magnetometer.sv
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: now_ms, x_raw, y_raw
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: heading_deg; tuser: no_heading, fresh
// i_cfg_*   in   i_cfg_we, no wait              i_cfg_addr selects register, i_cfg_wdata
//
// The back end takes an item that is recomputed through the CORDIC loop
// through states MUL, PRE, ITER and DONE, and a held or special-case item
// from IDLE to DONE; the single shared CORDIC unit pops a new item only in IDLE.
// A two-entry queue sits between classification and the CORDIC loop, and the
// result register lets the next item proceed while a result waits.
// Reset is synchronous; it clears the queue, state and held heading.
module compass_heading_from_magnetometer #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] now_ms, [47:32] x_raw, [63:48] y_raw
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [8:0] heading_deg, [15:9] zero
    output logic [1:0]  m_axis_tuser    // [0] no_heading, [1] fresh
);

    cmphd_pkg::t_cfg r_cfg;
    cmphd_pkg::t_job front_job;
    cmphd_pkg::t_job q_job;
    logic            q_full;
    logic            q_push;
    logic            q_pop;
    logic            q_valid;
    logic [8:0]      heading_deg;
    logic            no_heading;
    logic            fresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_offset        <= 16'sd0;
            r_cfg.x_scale         <= 15'd1;
            r_cfg.y_offset        <= 16'sd0;
            r_cfg.y_scale         <= 15'd1;
            r_cfg.min_interval_ms <= 8'd15;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                cmphd_pkg::REG_X_OFFSET: r_cfg.x_offset        <= i_cfg_wdata;
                cmphd_pkg::REG_X_SCALE:  r_cfg.x_scale         <= i_cfg_wdata[14:0];
                cmphd_pkg::REG_Y_OFFSET: r_cfg.y_offset        <= i_cfg_wdata;
                cmphd_pkg::REG_Y_SCALE:  r_cfg.y_scale         <= i_cfg_wdata[14:0];
                cmphd_pkg::REG_MIN_INT:  r_cfg.min_interval_ms <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    cmphd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_now_ms (s_axis_tdata[31:0]),
        .i_x_raw  (s_axis_tdata[47:32]),
        .i_y_raw  (s_axis_tdata[63:48]),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_job    (front_job)
    );

    cmphd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    cmphd_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_valid     (q_valid),
        .i_q_job       (q_job),
        .o_q_pop       (q_pop),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_heading_deg (heading_deg),
        .o_no_heading  (no_heading),
        .o_fresh       (fresh)
    );

    assign m_axis_tdata = {7'd0, heading_deg};
    assign m_axis_tuser = {fresh, no_heading};

endmodule

FILE: hw/rtl/cmphd_checker.sv
module cmphd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // result must wait until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output item changed while stalled");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[8:0] <= 9'd360 && m_axis_tdata[15:9] == 7'd0)
        else $error("heading out of range");

    a_no_heading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[8:0] == 9'd0)
        else $error("no_heading with nonzero heading");

    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid straight after reset");

endmodule

bind compass_heading_from_magnetometer cmphd_checker u_cmphd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
